>>> sv/tcch_pkg.sv
// shared constants, types and angle table for the compass heading block
`default_nettype none
package tcch_pkg;

  // sample and datapath sizing
  localparam int SAMPLE_WIDTH = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int FRAC_BITS    = 30 - SAMPLE_WIDTH;
  localparam int DW           = 36;
  localparam int AW           = 25;
  localparam int TABLE_LEN    = 24;
  localparam int NSTEP        = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int CW           = $clog2(NSTEP);
  localparam int CFG_W        = 16;
  localparam int CNT_W        = 32;

  // angle and gain constants
  localparam logic signed [AW-1:0] ANG_HALF_TURN = 25'sd5898240;
  localparam logic signed [30:0]   INV_GAIN_Q30  = 31'sd652032874;
  localparam logic signed [17:0]   FULL_TURN_OUT = 18'sd46080;
  localparam logic signed [17:0]   TWO_TURN_OUT  = 18'sd92160;
  localparam logic signed [AW-1:0] HALF_TURN_OUT = 25'sd23040;

  // configuration register indexes
  localparam logic [1:0] REG_OFFSET_X    = 2'd0;
  localparam logic [1:0] REG_OFFSET_Y    = 2'd1;
  localparam logic [1:0] REG_OFFSET_Z    = 2'd2;
  localparam logic [1:0] REG_DECLINATION = 2'd3;

  // input opcodes
  localparam logic OP_GRAVITY = 1'b0;
  localparam logic OP_MAG     = 1'b1;

  // atan(2^-i) in 1/32768 degree
  localparam logic signed [AW-1:0] ATAN_TAB [0:TABLE_LEN-1] = '{
    25'sd1474560, 25'sd870484, 25'sd459940, 25'sd233473, 25'sd117189, 25'sd58652,
    25'sd29333, 25'sd14667, 25'sd7334, 25'sd3667, 25'sd1833, 25'sd917,
    25'sd458, 25'sd229, 25'sd115, 25'sd57, 25'sd29, 25'sd14,
    25'sd7, 25'sd4, 25'sd2, 25'sd1, 25'sd0, 25'sd0
  };

  // request into the rotation engine
  typedef struct packed {
    logic                 start;
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] b;
  } cord_cmd_t;

  // result from the rotation engine
  typedef struct packed {
    logic                 done;
    logic                 gained;
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] b;
    logic signed [AW-1:0] ang;
  } cord_res_t;

  // raw difference to fixed point
  function automatic logic signed [DW-1:0] scale(input logic signed [SAMPLE_WIDTH:0] v);
    logic signed [DW-1:0] e;
    e = DW'(v);
    return e <<< FRAC_BITS;
  endfunction

endpackage
`default_nettype wire

>>> sv/tcch_if.sv
// sample and heading channel interfaces
`default_nettype none
interface tcch_in_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     opcode;
  logic signed [tcch_pkg::SAMPLE_WIDTH-1:0] vec_x;
  logic signed [tcch_pkg::SAMPLE_WIDTH-1:0] vec_y;
  logic signed [tcch_pkg::SAMPLE_WIDTH-1:0] vec_z;
  modport source (output valid, opcode, vec_x, vec_y, vec_z, input ready);
  modport sink   (input valid, opcode, vec_x, vec_y, vec_z, output ready);
endinterface

interface tcch_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [15:0]             magnetic_heading;
  logic [15:0]                    true_heading;
  logic [tcch_pkg::CNT_W-1:0]     update_number;
  logic                           tilt_applied;
  modport source (output valid, magnetic_heading, true_heading, update_number, tilt_applied,
                  input ready);
  modport sink   (input valid, magnetic_heading, true_heading, update_number, tilt_applied,
                  output ready);
endinterface
`default_nettype wire

>>> sv/tilt_compensated_compass_heading.sv
// top level: tilt-compensated compass heading sequencer
//
// in_ch carries sensor requests: opcode 0 stores a gravity vector (no result),
// opcode 1 is a magnetometer vector that yields one heading request on out_ch.
// cfg_we/cfg_index/cfg_data write the hard-iron offsets (0..2) and the
// declination (3); write only while the block is idle.
// A gravity request is stored on acceptance. A magnetometer request runs through one
// shared cordic engine (one micro-rotation per cycle, 16 steps) and a
// two-phase gain multiplier: an untilted request takes a heading pass only,
// and a request after a gravity vector takes roll, pitch and heading passes
// plus up to four gain corrections.
// in_ch.ready is high only while the sequencer is idle; one request at a time.
// A finished heading sits in an output register; if out_ch is stalled the
// sequencer holds its last step until the register frees, and new requests
// are taken as soon as the result has moved into the register.
// Synchronous reset clears the offsets, declination, gravity, the update
// counter and all handshake state.
`default_nettype none
module tilt_compensated_compass_heading (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [tcch_pkg::CFG_W-1:0] cfg_data,
  tcch_in_if.sink                         in_ch,
  tcch_out_if.source                      out_ch
);

  localparam int SW = tcch_pkg::SAMPLE_WIDTH;
  localparam int DW = tcch_pkg::DW;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_ROLL    = 4'd1;
  localparam logic [3:0] S_ROLL_W  = 4'd2;
  localparam logic [3:0] S_UNS     = 4'd3;
  localparam logic [3:0] S_UNS_W   = 4'd4;
  localparam logic [3:0] S_PITCH   = 4'd5;
  localparam logic [3:0] S_PITCH_W = 4'd6;
  localparam logic [3:0] S_HEAD    = 4'd7;
  localparam logic [3:0] S_HEAD_W  = 4'd8;
  localparam logic [3:0] S_FIN     = 4'd9;

  localparam logic [1:0] SEL_GZ  = 2'd0;
  localparam logic [1:0] SEL_U   = 2'd1;
  localparam logic [1:0] SEL_TCY = 2'd2;
  localparam logic [1:0] SEL_TCX = 2'd3;

  logic [3:0] state;
  logic [1:0] sel;

  // configuration and persistent state
  logic signed [SW-1:0]   offset_x, offset_y, offset_z;
  logic signed [15:0]     declination;
  logic signed [SW-1:0]   gravity_x, gravity_y, gravity_z;
  logic                   gravity_seen;
  logic [tcch_pkg::CNT_W-1:0] update_counter;

  // working vectors
  logic signed [DW-1:0]   wgz, u, tcy, tcx, hx, hy;
  logic signed [tcch_pkg::AW-1:0] ang;
  logic                   tilt;

  // output register
  logic                   out_valid;
  logic signed [15:0]     out_mag;
  logic [15:0]            out_true;
  logic [tcch_pkg::CNT_W-1:0] out_num;
  logic                   out_tilt;

  tcch_pkg::cord_cmd_t    ccmd;
  tcch_pkg::cord_res_t    cres;
  logic                   us_start, us_done;
  logic signed [DW-1:0]   us_din, us_dout;

  tcch_cordic u_cordic (.clk(clk), .rst(rst), .cmd(ccmd), .res(cres));

  tcch_unscale u_unscale (
    .clk(clk), .rst(rst), .start(us_start), .din(us_din), .done(us_done), .dout(us_dout)
  );

  logic in_acc;
  assign in_ch.ready = (state == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // offset-corrected field
  logic signed [DW-1:0] fx, fy, fz, gx_s, gy_s, gz_s;
  always_comb begin
    fx   = tcch_pkg::scale((SW+1)'(in_ch.vec_x) - (SW+1)'(offset_x));
    fy   = tcch_pkg::scale((SW+1)'(in_ch.vec_y) - (SW+1)'(offset_y));
    fz   = tcch_pkg::scale((SW+1)'(in_ch.vec_z) - (SW+1)'(offset_z));
    gx_s = tcch_pkg::scale((SW+1)'(gravity_x));
    gy_s = tcch_pkg::scale((SW+1)'(gravity_y));
    gz_s = tcch_pkg::scale((SW+1)'(gravity_z));
  end

  // engine request mux
  always_comb begin
    ccmd.start = 1'b0;
    ccmd.x     = hx;
    ccmd.y     = hy;
    ccmd.a     = '0;
    ccmd.b     = '0;
    case (state)
      S_ROLL: begin
        ccmd.start = 1'b1;
        ccmd.x     = gz_s;
        ccmd.y     = gy_s;
        ccmd.a     = u;
        ccmd.b     = tcy;
      end
      S_PITCH: begin
        ccmd.start = 1'b1;
        ccmd.x     = wgz;
        ccmd.y     = gx_s;
        ccmd.a     = tcx;
        ccmd.b     = u;
      end
      S_HEAD: ccmd.start = 1'b1;
      default: ccmd.start = 1'b0;
    endcase
  end

  // gain multiplier operand select
  always_comb begin
    us_start = (state == S_UNS);
    case (sel)
      SEL_GZ:  us_din = wgz;
      SEL_U:   us_din = u;
      SEL_TCY: us_din = tcy;
      default: us_din = tcx;
    endcase
  end

  // rounding, clamp and wrap
  logic signed [tcch_pkg::AW-1:0] rnd, clamped;
  logic signed [17:0]             tsum, twrap;
  always_comb begin
    rnd = (ang + tcch_pkg::AW'(128)) >>> 8;
    if (rnd > tcch_pkg::HALF_TURN_OUT) begin
      clamped = tcch_pkg::HALF_TURN_OUT;
    end else if (rnd < -tcch_pkg::HALF_TURN_OUT) begin
      clamped = -tcch_pkg::HALF_TURN_OUT;
    end else begin
      clamped = rnd;
    end
    tsum = 18'(clamped) + 18'(declination);
    if (tsum < -tcch_pkg::FULL_TURN_OUT) begin
      twrap = tsum + tcch_pkg::TWO_TURN_OUT;
    end else if (tsum < 0) begin
      twrap = tsum + tcch_pkg::FULL_TURN_OUT;
    end else if (tsum >= tcch_pkg::FULL_TURN_OUT) begin
      twrap = tsum - tcch_pkg::FULL_TURN_OUT;
    end else begin
      twrap = tsum;
    end
  end

  logic out_free;
  assign out_free = !out_valid || out_ch.ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x    <= '0;
      offset_y    <= '0;
      offset_z    <= '0;
      declination <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tcch_pkg::REG_OFFSET_X:    offset_x    <= cfg_data[SW-1:0];
        tcch_pkg::REG_OFFSET_Y:    offset_y    <= cfg_data[SW-1:0];
        tcch_pkg::REG_OFFSET_Z:    offset_z    <= cfg_data[SW-1:0];
        tcch_pkg::REG_DECLINATION: declination <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      sel            <= SEL_GZ;
      gravity_x      <= '0;
      gravity_y      <= '0;
      gravity_z      <= '0;
      gravity_seen   <= 1'b0;
      update_counter <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (in_ch.opcode == tcch_pkg::OP_GRAVITY) begin
              gravity_x    <= in_ch.vec_x;
              gravity_y    <= in_ch.vec_y;
              gravity_z    <= in_ch.vec_z;
              gravity_seen <= 1'b1;
            end else begin
              tcx  <= fx;
              tcy  <= fy;
              u    <= fz;
              hx   <= fx;
              hy   <= -fy;
              tilt <= gravity_seen;
              state <= gravity_seen ? S_ROLL : S_HEAD;
            end
          end
        end
        S_ROLL: state <= S_ROLL_W;
        S_ROLL_W: begin
          if (cres.done) begin
            wgz <= cres.x;
            u   <= cres.a;
            tcy <= cres.b;
            sel <= SEL_GZ;
            state <= cres.gained ? S_UNS : S_PITCH;
          end
        end
        S_UNS: state <= S_UNS_W;
        S_UNS_W: begin
          if (us_done) begin
            case (sel)
              SEL_GZ: begin
                wgz   <= us_dout;
                sel   <= SEL_U;
                state <= S_UNS;
              end
              SEL_U: begin
                u     <= us_dout;
                sel   <= SEL_TCY;
                state <= S_UNS;
              end
              SEL_TCY: begin
                tcy   <= us_dout;
                state <= S_PITCH;
              end
              default: begin
                hx    <= us_dout;
                hy    <= -tcy;
                state <= S_HEAD;
              end
            endcase
          end
        end
        S_PITCH: state <= S_PITCH_W;
        S_PITCH_W: begin
          if (cres.done) begin
            tcx <= cres.a;
            u   <= cres.b;
            hx  <= cres.a;
            hy  <= -tcy;
            sel <= SEL_TCX;
            state <= cres.gained ? S_UNS : S_HEAD;
          end
        end
        S_HEAD: state <= S_HEAD_W;
        S_HEAD_W: begin
          if (cres.done) begin
            ang   <= cres.ang;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            update_counter <= update_counter + 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      out_mag  <= clamped[15:0];
      out_true <= twrap[15:0];
      out_num  <= update_counter + 1'b1;
      out_tilt <= tilt;
    end
  end

  assign out_ch.valid            = out_valid;
  assign out_ch.magnetic_heading = out_mag;
  assign out_ch.true_heading     = out_true;
  assign out_ch.update_number    = out_num;
  assign out_ch.tilt_applied     = out_tilt;

  // engine results only arrive while the sequencer waits for them
  a_cord_done_wait: assert property (@(posedge clk) disable iff (rst)
    cres.done |-> (state == S_ROLL_W || state == S_PITCH_W || state == S_HEAD_W))
    else $error("cordic result outside a wait state");

  // gain correction only completes in its wait state
  a_uns_done_wait: assert property (@(posedge clk) disable iff (rst)
    us_done |-> (state == S_UNS_W))
    else $error("gain correction result outside its wait state");

  // headings stay in range
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.true_heading < 16'd46080 &&
                      out_ch.magnetic_heading <= 16'sd23040 &&
                      out_ch.magnetic_heading >= -16'sd23040))
    else $error("heading out of range");

  // each result bumps the update counter by one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_free) |=> (update_counter == $past(update_counter) + 1'b1))
    else $error("update counter did not advance");

endmodule
`default_nettype wire

>>> sv/tcch_cordic.sv
// iterative cordic vectoring engine, one micro-rotation per cycle
`default_nettype none
module tcch_cordic (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire tcch_pkg::cord_cmd_t cmd,
  output tcch_pkg::cord_res_t      res
);

  logic signed [tcch_pkg::DW-1:0] x, y, a, b;
  logic signed [tcch_pkg::AW-1:0] acc;
  logic [tcch_pkg::CW-1:0]        cnt;
  logic                           busy;
  logic                           done;
  logic                           gained;

  // start-time quadrant fold
  logic                           neg, zero;
  logic signed [tcch_pkg::DW-1:0] sx, sy, sa, sb;
  logic signed [tcch_pkg::AW-1:0] sacc;

  always_comb begin
    neg  = cmd.x[tcch_pkg::DW-1];
    zero = (cmd.x == '0) && (cmd.y == '0);
    sx   = neg ? -cmd.x : cmd.x;
    sy   = neg ? -cmd.y : cmd.y;
    sa   = neg ? -cmd.a : cmd.a;
    sb   = neg ? -cmd.b : cmd.b;
    if (!neg) begin
      sacc = '0;
    end else if (cmd.y[tcch_pkg::DW-1]) begin
      sacc = -tcch_pkg::ANG_HALF_TURN;
    end else begin
      sacc = tcch_pkg::ANG_HALF_TURN;
    end
  end

  // one micro-rotation
  logic                           pos;
  logic signed [tcch_pkg::DW-1:0] dx, dy, da, db;

  always_comb begin
    pos = !y[tcch_pkg::DW-1] && (y != '0);
    dx  = y >>> cnt;
    dy  = x >>> cnt;
    da  = b >>> cnt;
    db  = a >>> cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done   <= 1'b0;
      gained <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        cnt <= '0;
        if (zero) begin
          x      <= cmd.x;
          y      <= cmd.y;
          a      <= cmd.a;
          b      <= cmd.b;
          acc    <= '0;
          gained <= 1'b0;
          done   <= 1'b1;
        end else begin
          x      <= sx;
          y      <= sy;
          a      <= sa;
          b      <= sb;
          acc    <= sacc;
          gained <= (sy != '0);
          busy   <= (sy != '0);
          done   <= (sy == '0);
        end
      end else if (busy) begin
        if (pos) begin
          x   <= x + dx;
          y   <= y - dy;
          a   <= a + da;
          b   <= b - db;
          acc <= acc + tcch_pkg::ATAN_TAB[cnt];
        end else begin
          x   <= x - dx;
          y   <= y + dy;
          a   <= a - da;
          b   <= b + db;
          acc <= acc - tcch_pkg::ATAN_TAB[cnt];
        end
        if (cnt == tcch_pkg::CW'(tcch_pkg::NSTEP - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  assign res.done   = done;
  assign res.gained = gained;
  assign res.x      = x;
  assign res.y      = y;
  assign res.a      = a;
  assign res.b      = b;
  assign res.ang    = acc;

endmodule
`default_nettype wire

>>> sv/tcch_unscale.sv
// gain removal: multiply by 1/K in two partial products and floor
`default_nettype none
module tcch_unscale (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic signed [tcch_pkg::DW-1:0]    din,
  output logic                                   done,
  output logic signed [tcch_pkg::DW-1:0]         dout
);

  localparam int LO = 18;
  localparam int HI = tcch_pkg::DW - LO;
  localparam int PW = 19 + 31;
  localparam int AC = PW + LO;

  logic signed [tcch_pkg::DW-1:0] v;
  logic [1:0]                     ph;
  logic signed [AC-1:0]           acc;
  logic signed [18:0]             mop;
  logic signed [PW-1:0]           prod;

  // shared multiplier: low part unsigned, then high part signed
  always_comb begin
    if (ph == 2'd1) begin
      mop = signed'({1'b0, v[LO-1:0]});
    end else begin
      mop = 19'(signed'(v[tcch_pkg::DW-1:LO]));
    end
    prod = PW'(mop) * PW'(tcch_pkg::INV_GAIN_Q30);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph   <= 2'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (ph)
        2'd0: begin
          if (start) begin
            v  <= din;
            ph <= 2'd1;
          end
        end
        2'd1: begin
          acc <= AC'(prod);
          ph  <= 2'd2;
        end
        2'd2: begin
          acc  <= acc + signed'({prod, {LO{1'b0}}});
          ph   <= 2'd0;
          done <= 1'b1;
        end
        default: ph <= 2'd0;
      endcase
    end
  end

  assign dout = acc[30 +: tcch_pkg::DW];

endmodule
`default_nettype wire

>>> test/tcch_checker.sv
// heading predictor and result checker for the tilt-compensated compass block
`timescale 1ns / 1ps
`default_nettype none
module tcch_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  tcch_in_if               in_ch,
  tcch_out_if              out_ch,
  output int               errors,
  output int               waiting,
  output int               headings_checked,
  output int               samples_taken
);

  localparam longint ONE       = longint'(1) << tcch_pkg::FRAC_BITS;
  localparam longint HALF_ANG  = 5898240;
  localparam longint INV_GAIN  = 652032874;
  localparam int     STEPS     = 16;
  localparam int     FULL_OUT  = 46080;
  localparam int     HALF_OUT  = 23040;

  // atan(2^-i) in 1/32768 degree
  localparam longint ANGLE_STEP [0:STEPS-1] = '{
    1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
    7334, 3667, 1833, 917, 458, 229, 115, 57
  };

  typedef struct {
    logic signed [15:0] mag;
    logic [15:0]        tru;
    logic [31:0]        num;
    logic               tilt;
  } heading_t;

  heading_t           heading_q[$];
  logic signed [15:0] hard_iron_x, hard_iron_y, hard_iron_z, decl;
  logic signed [15:0] grav_x, grav_y, grav_z;
  logic               grav_valid;
  logic [31:0]        mag_count;

  assign waiting = heading_q.size();

  // rotate (x, y) onto +x and carry (a, b) along
  task automatic rotate_to_x(inout longint x, inout longint y, inout longint a,
                             inout longint b, output longint ang, output bit gained);
    longint dx, dy, da, db, acc;
    acc = 0;
    gained = 0;
    if (x == 0 && y == 0) begin
      ang = 0;
      return;
    end
    if (x < 0) begin
      acc = (y >= 0) ? HALF_ANG : -HALF_ANG;
      x = -x; y = -y; a = -a; b = -b;
    end
    if (y != 0) begin
      gained = 1;
      for (int i = 0; i < STEPS; i++) begin
        dx = y >>> i; dy = x >>> i; da = b >>> i; db = a >>> i;
        if (y > 0) begin
          x += dx; y -= dy; a += da; b -= db; acc += ANGLE_STEP[i];
        end else begin
          x -= dx; y += dy; a -= da; b += db; acc -= ANGLE_STEP[i];
        end
      end
    end
    ang = acc;
  endtask

  function automatic longint ungain(longint v);
    return (v * INV_GAIN) >>> 30;
  endfunction

  // expected heading for one magnetometer request
  task automatic predict_heading(logic signed [15:0] vx, logic signed [15:0] vy,
                                 logic signed [15:0] vz);
    longint fx, fy, fz, gx, gy, gz, u, tcx, tcy, hx, hy, ang, d0, d1, rounded;
    bit gained;
    int tru;
    heading_t h;
    fx = (longint'(vx) - longint'(hard_iron_x)) * ONE;
    fy = (longint'(vy) - longint'(hard_iron_y)) * ONE;
    fz = (longint'(vz) - longint'(hard_iron_z)) * ONE;
    if (grav_valid) begin
      gx = longint'(grav_x) * ONE;
      gy = longint'(grav_y) * ONE;
      gz = longint'(grav_z) * ONE;
      u = fz; tcy = fy; tcx = fx;
      // roll then pitch
      rotate_to_x(gz, gy, u, tcy, ang, gained);
      if (gained) begin
        gz = ungain(gz); u = ungain(u); tcy = ungain(tcy);
      end
      rotate_to_x(gz, gx, tcx, u, ang, gained);
      if (gained) tcx = ungain(tcx);
      hx = tcx; hy = -tcy;
    end else begin
      hx = fx; hy = -fy;
    end
    d0 = 0; d1 = 0;
    rotate_to_x(hx, hy, d0, d1, ang, gained);
    rounded = (ang + 128) >>> 8;
    if (rounded > HALF_OUT) rounded = HALF_OUT;
    if (rounded < -HALF_OUT) rounded = -HALF_OUT;
    tru = (int'(rounded) + int'(decl)) % FULL_OUT;
    if (tru < 0) tru += FULL_OUT;
    mag_count = mag_count + 1;
    h.mag = 16'(rounded);
    h.tru = 16'(tru);
    h.num = mag_count;
    h.tilt = grav_valid;
    heading_q.push_back(h);
  endtask

  task automatic report(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // track config, predict on accepted samples, compare on accepted headings
  always @(posedge clk) begin
    heading_t h;
    if (rst) begin
      hard_iron_x <= 0; hard_iron_y <= 0; hard_iron_z <= 0; decl <= 0;
      grav_x = 0; grav_y = 0; grav_z = 0; grav_valid = 0;
      mag_count = 0;
      heading_q.delete();
      errors = 0; headings_checked = 0; samples_taken = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tcch_pkg::REG_OFFSET_X:    hard_iron_x <= cfg_data;
          tcch_pkg::REG_OFFSET_Y:    hard_iron_y <= cfg_data;
          tcch_pkg::REG_OFFSET_Z:    hard_iron_z <= cfg_data;
          tcch_pkg::REG_DECLINATION: decl <= cfg_data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        samples_taken++;
        if (in_ch.opcode == tcch_pkg::OP_GRAVITY) begin
          grav_x = in_ch.vec_x; grav_y = in_ch.vec_y; grav_z = in_ch.vec_z;
          grav_valid = 1;
        end else begin
          predict_heading(in_ch.vec_x, in_ch.vec_y, in_ch.vec_z);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        headings_checked++;
        if (heading_q.size() == 0) begin
          report("unexpected heading, update_number", out_ch.update_number, 0);
        end else begin
          h = heading_q.pop_front();
          if (out_ch.magnetic_heading !== h.mag)
            report("magnetic_heading", out_ch.magnetic_heading, h.mag);
          if (out_ch.true_heading !== h.tru)
            report("true_heading", out_ch.true_heading, h.tru);
          if (out_ch.update_number !== h.num)
            report("update_number", out_ch.update_number, h.num);
          if (out_ch.tilt_applied !== h.tilt)
            report("tilt_applied", out_ch.tilt_applied, h.tilt);
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> test/tb_tilt_compensated_compass_heading.sv
// testbench top: clock, reset, sample stimulus, config phases and verdict
`timescale 1ns / 1ps
`default_nettype none
module tb_tilt_compensated_compass_heading;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 600;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  int          errors, waiting, headings_checked, samples_taken;
  int          send_idle_pct, recv_stall_pct;
  bit          hold_req, hold_done;
  int          hold_left;
  int          quiet_cycles;

  tcch_in_if  in_ch ();
  tcch_out_if out_ch ();

  tilt_compensated_compass_heading i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  tcch_checker i_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_ch            (in_ch),
    .out_ch           (out_ch),
    .errors           (errors),
    .waiting          (waiting),
    .headings_checked (headings_checked),
    .samples_taken    (samples_taken)
  );

  // 20 ns clock
  initial clk = 0;
  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // heading receiver: random stalls plus one long hold-off
  initial begin
    out_ch.ready = 0;
    hold_left = 0;
    hold_done = 0;
  end
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1;
    end
    if (hold_left > 0) begin
      out_ch.ready = 0;
      hold_left--;
    end else begin
      out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ready only changes at a rising edge, so it is checked at the falling edge
  task automatic send_sample(logic op, logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_ch.valid = 1;
    in_ch.opcode = op;
    in_ch.vec_x = x;
    in_ch.vec_y = y;
    in_ch.vec_z = z;
    while (!in_ch.ready) @(negedge clk);
    @(negedge clk);
    in_ch.valid = 0;
  endtask

  // wait for all headings, then let a gravity request finish
  task automatic drain();
    while (waiting != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic write_all(logic [15:0] ox, logic [15:0] oy, logic [15:0] oz,
                           logic [15:0] dec);
    drain();
    write_reg(tcch_pkg::REG_OFFSET_X, ox);
    write_reg(tcch_pkg::REG_OFFSET_Y, oy);
    write_reg(tcch_pkg::REG_OFFSET_Z, oz);
    write_reg(tcch_pkg::REG_DECLINATION, dec);
  endtask

  // mix of full-range, small and extreme sample values
  function automatic logic [15:0] pick_value();
    int k;
    k = $urandom_range(99);
    if (k < 55) return 16'($urandom);
    if (k < 80) return 16'($urandom_range(400)) - 16'd200;
    if (k < 90) return 16'($urandom_range(30000)) - 16'd15000;
    case ($urandom_range(4))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'h0001;
    endcase
  endfunction

  function automatic logic [15:0] pick_decl();
    if ($urandom_range(9) < 8) return 16'($urandom_range(46080)) - 16'd23040;
    return 16'($urandom);
  endfunction

  // sometimes a gravity vector, then a burst of magnetometer readings
  task automatic random_burst(inout int sent);
    int n;
    if ($urandom_range(99) < 30) begin
      send_sample(tcch_pkg::OP_GRAVITY, pick_value(), pick_value(), pick_value());
      sent++;
    end
    n = $urandom_range(6, 1);
    repeat (n) begin
      send_sample(tcch_pkg::OP_MAG, pick_value(), pick_value(), pick_value());
      sent++;
    end
  endtask

  task automatic random_phase(int idle, int stall, int count);
    int sent;
    sent = 0;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    write_all(pick_value(), pick_value(), pick_value(), pick_decl());
    while (sent < count) random_burst(sent);
  endtask

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_index = tcch_pkg::REG_OFFSET_X;
    cfg_data = 0;
    in_ch.valid = 0;
    in_ch.opcode = tcch_pkg::OP_GRAVITY;
    in_ch.vec_x = 0;
    in_ch.vec_y = 0;
    in_ch.vec_z = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 0;
    quiet_cycles = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // untilted headings straight out of reset
    send_sample(tcch_pkg::OP_MAG, 16'sd1000, 16'sd0, 16'sd0);
    send_sample(tcch_pkg::OP_MAG, -16'sd1000, 16'sd0, 16'sd5);
    send_sample(tcch_pkg::OP_MAG, 16'sd0, 16'sd0, 16'sd0);
    send_sample(tcch_pkg::OP_MAG, 16'sd0, 16'sd700, -16'sd300);
    send_sample(tcch_pkg::OP_MAG, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send_sample(tcch_pkg::OP_MAG, 16'sh8000, -16'sd1, 16'sh8000);
    send_sample(tcch_pkg::OP_MAG, -16'sd500, 16'sd1, 16'sd0);
    // gravity seen but all zero
    send_sample(tcch_pkg::OP_GRAVITY, 16'sd0, 16'sd0, 16'sd0);
    send_sample(tcch_pkg::OP_MAG, 16'sd300, -16'sd400, 16'sd200);
    // level, inverted and steep gravity
    send_sample(tcch_pkg::OP_GRAVITY, 16'sd0, 16'sd0, 16'sd16384);
    send_sample(tcch_pkg::OP_MAG, 16'sd200, 16'sd150, -16'sd400);
    send_sample(tcch_pkg::OP_GRAVITY, 16'sd0, 16'sd0, -16'sd16384);
    send_sample(tcch_pkg::OP_MAG, -16'sd200, 16'sd150, 16'sd400);
    send_sample(tcch_pkg::OP_GRAVITY, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send_sample(tcch_pkg::OP_MAG, 16'sh8000, 16'sh7fff, 16'sh8000);
    send_sample(tcch_pkg::OP_GRAVITY, -16'sd3000, 16'sd2000, 16'sd15000);
    send_sample(tcch_pkg::OP_MAG, 16'sd250, -16'sd90, -16'sd380);
    // offset extremes and declination extremes
    write_all(16'h8000, 16'h7fff, 16'h8000, 16'h8000);
    send_sample(tcch_pkg::OP_MAG, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send_sample(tcch_pkg::OP_MAG, 16'sh8000, 16'sh7fff, 16'sh8000);
    write_all(16'h7fff, 16'h8000, 16'h7fff, 16'h7fff);
    send_sample(tcch_pkg::OP_MAG, 16'sh8000, 16'sh7fff, 16'sh8000);
    write_all(16'd0, 16'd0, 16'd0, 16'd23040);
    send_sample(tcch_pkg::OP_MAG, -16'sd1000, 16'sd0, 16'sd0);
    write_all(16'd0, 16'd0, 16'd0, -16'sd23040);
    send_sample(tcch_pkg::OP_MAG, 16'sd1000, 16'sd0, 16'sd0);
    send_sample(tcch_pkg::OP_MAG, 16'sd0, -16'sd1000, 16'sd0);

    // long receiver hold-off while samples keep coming
    write_all(16'd0, 16'd0, 16'd0, 16'd0);
    hold_req = 1;
    for (int i = 0; i < 20; i++)
      send_sample(tcch_pkg::OP_MAG, pick_value(), pick_value(), pick_value());

    random_phase(0, 0, 280);
    random_phase(65, 0, 280);
    random_phase(0, 65, 280);
    random_phase(36, 36, 280);

    drain();
    $display("covered %0d accepted samples and %0d checked headings", samples_taken,
             headings_checked);
    $display("config phases included offset and declination extremes and a long hold-off");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
sv/tcch_pkg.sv
sv/tcch_if.sv
sv/tcch_cordic.sv
sv/tcch_unscale.sv
sv/tilt_compensated_compass_heading.sv
test/tcch_checker.sv
test/tb_tilt_compensated_compass_heading.sv
